/* rtl/imlf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package imlf_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int RAW_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CPG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_CPD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_CONFIRM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_CONFIRM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIFTED   = 3'd7;

    localparam logic [14:0] RST_ACCEL_CPG    = 15'd8192;
    localparam logic [15:0] RST_GYRO_CPD     = 16'd16768;
    localparam logic [9:0]  RST_INTERVAL     = 10'd20;
    localparam logic [6:0]  RST_CAL_SAMPLES  = 7'd50;
    localparam logic [13:0] RST_LIFT_CONFIRM = 14'd80;
    localparam logic [13:0] RST_FLAT_CONFIRM = 14'd650;
    localparam logic [15:0] RST_MIN_LIFTED   = 16'd800;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_LIFTED = 2'd1;
    localparam logic [1:0] EV_FLAT   = 2'd2;

    localparam int ONE_G_Q13     = 8192;
    localparam int GRAV_ALPHA    = 5243;
    localparam int ACC_SHIFT     = 13;
    localparam int GYR_SHIFT     = 12;
    localparam int UNIT_SHIFT    = 15;
    localparam int BASE_MIN_NORM = 9;
    localparam int GRAV_MIN_NORM = 2098;

    localparam int DOT_FLAT   = 32276;
    localparam int DOT_RETURN = 31621;
    localparam int DOT_LIFT   = 29688;
    localparam int ACC_STATIC = 492;
    localparam int ACC_RETURN = 983;
    localparam int ACC_PICKUP = 983;
    localparam int ACC_CAL    = 1229;
    localparam int GYR_STATIC = 48;
    localparam int GYR_RETURN = 192;
    localparam int GYR_PICKUP = 288;
    localparam int GYR_CAL    = 1920;

    typedef enum logic [1:0] {
        PH_CAL,
        PH_FLAT,
        PH_LIFT
    } t_phase;

    typedef enum logic [1:0] {
        VS_ACC,
        VS_GYR,
        VS_BASE,
        VS_GRAV
    } t_vsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SC_START,
        S_SC_DIV,
        S_GRAV_MUL,
        S_GRAV_ACC,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_SQ_DONE,
        S_CAL_UPD,
        S_UN_START,
        S_UN_DIV,
        S_BIAS_START,
        S_BIAS_DIV,
        S_DOT_MUL,
        S_DOT_ACC,
        S_DECIDE,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

/* rtl/imu_lift_flat_detector.sv */
// Lift and return-to-flat detector for a six-axis motion sensor.
// Input channel (i_in_valid / o_in_stall) carries one poll per beat: a mode bit,
// a wrapping millisecond timestamp, a read status and raw accel and gyro counts.
// Output channel (o_out_valid / i_out_stall) returns exactly one result beat
// per input beat: the event code, the calibrating flag and the sample-used flag.
// Polls that are disabled, restart requests, early polls and failed reads are
// answered in the cycle after they are taken. A used sample runs through a
// shared multiplier, a restoring divider and a bit-serial square root under
// one sequencer. The divider produces one quotient bit a cycle over a
// dividend of MUL_W plus 15 bits, which is 40 bits at the default widths.
// The block takes no new beat while a sample is being worked on.
// A finished result waits in an output register while the receiver stalls; the
// next beat is taken once that register is free or is being emptied.
// Configuration writes take effect at once and are meant for idle periods.
// Writing enable from 0 to 1, and a restart beat, clear all run-time state.
// Reset clears run-time state and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module imu_lift_flat_detector
    import imlf_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int RAW_BITS   = RAW_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_mode,
    input  wire  [TIME_BITS-1:0]         i_now_ms,
    input  wire                          i_read_ok,
    input  wire  signed [RAW_BITS-1:0]   i_accel_x,
    input  wire  signed [RAW_BITS-1:0]   i_accel_y,
    input  wire  signed [RAW_BITS-1:0]   i_accel_z,
    input  wire  signed [RAW_BITS-1:0]   i_gyro_x,
    input  wire  signed [RAW_BITS-1:0]   i_gyro_y,
    input  wire  signed [RAW_BITS-1:0]   i_gyro_z,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [1:0]                   o_event_res,
    output logic                         o_calibrating,
    output logic                         o_sample_used
);

    localparam int BS_W  = COUNT_BITS + 17;
    localparam int GB_W  = COUNT_BITS + 21;
    localparam int MUL_W = (BS_W > 25) ? BS_W : 25;
    localparam int SQ_W  = 2 * MUL_W;
    localparam int DVD_W = MUL_W + UNIT_SHIFT;
    localparam int DVS_W = MUL_W;
    localparam int IT_W  = $clog2(DVD_W + 1);

    // Configuration registers.
    logic        r_enable;
    logic [14:0] r_accel_cpg;
    logic [15:0] r_gyro_cpd;
    logic [9:0]  r_interval;
    logic [6:0]  r_cal_samples;
    logic [13:0] r_lift_confirm;
    logic [13:0] r_flat_confirm;
    logic [15:0] r_min_lifted;

    // Sequencer.
    t_state r_state, n_state;
    t_vsel  r_sel;
    logic [2:0]      r_k;
    logic [IT_W-1:0] r_cnt;

    // Run-time state.
    t_phase                 r_phase;
    logic [TIME_BITS-1:0]   r_last;
    logic [TIME_BITS-1:0]   r_cand_t, r_flat_t, r_lift_t;
    logic                   r_cand_ok, r_flat_ok, r_lift_ok;
    logic [COUNT_BITS-1:0]  r_qc;
    logic signed [BS_W-1:0] r_bsum [0:2];
    logic signed [GB_W-1:0] r_gbsum [0:2];
    logic signed [15:0]     r_bu [0:2];
    logic signed [19:0]     r_gb [0:2];
    logic signed [23:0]     r_gf [0:2];
    logic                   r_primed;

    // Per-sample working registers.
    logic signed [RAW_BITS-1:0] r_raw [0:5];
    logic [TIME_BITS-1:0]       r_now;
    logic signed [15:0]         r_a [0:2];
    logic signed [19:0]         r_g [0:2];
    logic signed [15:0]         r_gu [0:2];
    logic [MUL_W-1:0]           r_ad, r_gn, r_nrm;
    logic signed [35:0]         r_dot;
    logic [1:0]                 r_ev;
    logic                       r_neg;

    // Shared units.
    logic signed [SQ_W-1:0] r_prod;
    logic [SQ_W-1:0]        r_sq;
    logic [SQ_W-1:0]        r_sn, r_sr, r_sb;
    logic [DVD_W-1:0]       r_quo;
    logic [DVS_W-1:0]       r_rem, r_dvs;

    // Output register.
    logic       r_out_vld;
    logic [1:0] r_out_ev;
    logic       r_out_cal;
    logic       r_out_used;

    logic in_acc, out_free, gate_ok, cfg_en_rise, rt_clr;
    logic [1:0] k3;

    assign k3          = r_k[1:0];
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign gate_ok     = TIME_BITS'(i_now_ms - r_last) >= r_interval;
    assign cfg_en_rise = i_cfg_we && (i_cfg_idx == CFG_ENABLE) && !r_enable
                         && i_cfg_wdata[0];
    assign rt_clr      = cfg_en_rise || (in_acc && r_enable && i_mode);

    assign o_out_valid   = r_out_vld;
    assign o_event_res   = r_out_ev;
    assign o_calibrating = r_out_cal;
    assign o_sample_used = r_out_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_accel_cpg    <= RST_ACCEL_CPG;
            r_gyro_cpd     <= RST_GYRO_CPD;
            r_interval     <= RST_INTERVAL;
            r_cal_samples  <= RST_CAL_SAMPLES;
            r_lift_confirm <= RST_LIFT_CONFIRM;
            r_flat_confirm <= RST_FLAT_CONFIRM;
            r_min_lifted   <= RST_MIN_LIFTED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:       r_enable       <= i_cfg_wdata[0];
                CFG_ACCEL_CPG:    r_accel_cpg    <= i_cfg_wdata[14:0];
                CFG_GYRO_CPD:     r_gyro_cpd     <= i_cfg_wdata;
                CFG_INTERVAL:     r_interval     <= i_cfg_wdata[9:0];
                CFG_CAL_SAMPLES:  r_cal_samples  <= i_cfg_wdata[6:0];
                CFG_LIFT_CONFIRM: r_lift_confirm <= i_cfg_wdata[13:0];
                CFG_FLAT_CONFIRM: r_flat_confirm <= i_cfg_wdata[13:0];
                CFG_MIN_LIFTED:   r_min_lifted   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Restoring divider, one quotient bit a cycle.
    logic [DVS_W:0]   div_rsh;
    logic [DVS_W+1:0] div_trial;
    logic             div_bit, div_last;
    logic [DVD_W-1:0] div_q;
    logic [DVS_W-1:0] div_rem;

    always_comb begin
        div_rsh   = {r_rem, r_quo[DVD_W-1]};
        div_trial = {1'b0, div_rsh} - {2'b00, r_dvs};
        div_bit   = !div_trial[DVS_W+1];
        div_q     = {r_quo[DVD_W-2:0], div_bit};
        div_rem   = div_bit ? div_trial[DVS_W-1:0] : div_rsh[DVS_W-1:0];
        div_last  = (r_cnt == IT_W'(1));
    end

    // Bit-serial integer square root.
    logic [SQ_W-1:0] sq_rb;
    logic            sq_ge;
    logic [MUL_W-1:0] sq_n;
    logic            n_small;

    always_comb begin
        sq_rb   = r_sr + r_sb;
        sq_ge   = r_sn >= sq_rb;
        sq_n    = r_sr[MUL_W-1:0];
        n_small = (r_sel == VS_BASE) ? (sq_n < MUL_W'(BASE_MIN_NORM))
                                     : (sq_n < MUL_W'(GRAV_MIN_NORM));
    end

    // Operand selection.
    logic signed [RAW_BITS-1:0] raw_v;
    logic signed [RAW_BITS:0]   raw_x;
    logic [RAW_BITS:0]          raw_mag;
    logic                       sc_acc;
    logic [15:0]                sc_div;
    logic [DVD_W-1:0]           sc_dvd, sc_lim;
    logic [20:0]                sc_qc, sc_sv;
    logic signed [23:0]         a24;
    logic signed [24:0]         g_diff;
    logic signed [MUL_W-1:0]    vec_el;
    logic [MUL_W-1:0]           vec_mag;
    logic [GB_W-1:0]            gb_mag;
    logic [15:0]                un_qc;
    logic signed [MUL_W-1:0]    mul_a, mul_b;

    always_comb begin
        raw_v   = r_raw[r_k];
        raw_x   = {raw_v[RAW_BITS-1], raw_v};
        raw_mag = raw_x[RAW_BITS] ? (RAW_BITS+1)'(-raw_x) : raw_x;
        sc_acc  = r_k < 3'd3;
        sc_div  = sc_acc ? {1'b0, r_accel_cpg} : r_gyro_cpd;
        if (sc_div == 16'd0) begin
            sc_div = 16'd1;
        end
        sc_dvd = (sc_acc ? (DVD_W'(raw_mag) << ACC_SHIFT) : (DVD_W'(raw_mag) << GYR_SHIFT))
                 + DVD_W'(sc_div >> 1);
        if (sc_acc) begin
            sc_lim = r_neg ? DVD_W'(32768) : DVD_W'(32767);
        end else begin
            sc_lim = r_neg ? DVD_W'(524288) : DVD_W'(524287);
        end
        sc_qc = (div_q > sc_lim) ? sc_lim[20:0] : div_q[20:0];
        sc_sv = r_neg ? 21'(-sc_qc) : sc_qc;

        a24    = $signed({r_a[k3], 8'd0});
        g_diff = 25'(a24) - 25'(r_gf[k3]);

        case (r_sel)
            VS_ACC:  vec_el = MUL_W'(r_a[k3]);
            VS_GYR:  vec_el = MUL_W'(r_g[k3]) - MUL_W'(r_gb[k3]);
            VS_BASE: vec_el = MUL_W'(r_bsum[k3]);
            VS_GRAV: vec_el = MUL_W'(r_gf[k3]);
            default: vec_el = '0;
        endcase
        vec_mag = vec_el[MUL_W-1] ? MUL_W'(-vec_el) : vec_el;
        gb_mag  = r_gbsum[k3][GB_W-1] ? GB_W'(-r_gbsum[k3]) : r_gbsum[k3];
        un_qc   = (div_q > DVD_W'(32767)) ? 16'd32767 : div_q[15:0];

        case (r_state)
            S_GRAV_MUL: begin
                mul_a = MUL_W'(g_diff);
                mul_b = MUL_W'(GRAV_ALPHA);
            end
            S_DOT_MUL: begin
                mul_a = MUL_W'(r_gu[k3]);
                mul_b = MUL_W'(r_bu[k3]);
            end
            default: begin
                mul_a = vec_el;
                mul_b = vec_el;
            end
        endcase
    end

    // Calibration update.
    logic                  cal_quiet, cal_done;
    logic [COUNT_BITS-1:0] qc_new;
    logic [6:0]            cal_need;

    always_comb begin
        cal_quiet = (r_ad < MUL_W'(ACC_CAL)) && (r_gn < MUL_W'(GYR_CAL));
        cal_need  = (r_cal_samples == 7'd0) ? 7'd1 : r_cal_samples;
        if (!cal_quiet) begin
            qc_new = '0;
        end else if (r_qc != {COUNT_BITS{1'b1}}) begin
            qc_new = r_qc + COUNT_BITS'(1);
        end else begin
            qc_new = r_qc;
        end
        cal_done = qc_new >= cal_need;
    end

    // Lift and flat decision.
    logic [35:0]          dot_abs;
    logic [20:0]          fd;
    logic                 st_stable, st_ret, st_lifted, st_pickup;
    t_phase               n_phase;
    logic                 n_cand_ok, n_flat_ok, n_lift_ok;
    logic [TIME_BITS-1:0] n_cand_t, n_flat_t, n_lift_t;
    logic [1:0]           n_ev;

    always_comb begin
        dot_abs   = r_dot[35] ? 36'(-r_dot) : r_dot;
        fd        = dot_abs[35:15];
        st_stable = (fd > 21'(DOT_FLAT)) && (r_gn < MUL_W'(GYR_STATIC))
                    && (r_ad < MUL_W'(ACC_STATIC));
        st_ret    = (fd > 21'(DOT_RETURN)) && (r_gn < MUL_W'(GYR_RETURN))
                    && (r_ad < MUL_W'(ACC_RETURN));
        st_lifted = fd < 21'(DOT_LIFT);
        st_pickup = (r_gn > MUL_W'(GYR_PICKUP)) || (r_ad > MUL_W'(ACC_PICKUP));
        n_phase   = r_phase;
        n_cand_ok = r_cand_ok;
        n_cand_t  = r_cand_t;
        n_flat_ok = r_flat_ok;
        n_flat_t  = r_flat_t;
        n_lift_ok = r_lift_ok;
        n_lift_t  = r_lift_t;
        n_ev      = EV_NONE;
        if (r_phase == PH_FLAT) begin
            if (st_pickup) begin
                n_cand_ok = 1'b0;
            end
            if (st_lifted) begin
                if (!n_cand_ok) begin
                    n_cand_t  = r_now;
                    n_cand_ok = 1'b1;
                end
                if (TIME_BITS'(r_now - n_cand_t) >= r_lift_confirm) begin
                    n_phase   = PH_LIFT;
                    n_lift_t  = r_now;
                    n_lift_ok = 1'b1;
                    n_cand_ok = 1'b0;
                    n_flat_ok = 1'b0;
                    n_ev      = EV_LIFTED;
                end
            end else begin
                n_cand_ok = 1'b0;
            end
        end else if (st_stable || st_ret) begin
            if (!r_flat_ok) begin
                n_flat_t  = r_now;
                n_flat_ok = 1'b1;
            end
            if ((!r_lift_ok || TIME_BITS'(r_now - r_lift_t) >= r_min_lifted)
                && TIME_BITS'(r_now - n_flat_t) >= r_flat_confirm) begin
                n_phase  = PH_FLAT;
                n_flat_t = r_now;
                n_ev     = EV_FLAT;
            end
        end else begin
            n_flat_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_enable && !i_mode && gate_ok && i_read_ok) begin
                    n_state = S_SC_START;
                end
            end
            S_SC_START: n_state = S_SC_DIV;
            S_SC_DIV: begin
                if (div_last) begin
                    n_state = (r_k == 3'd5) ? S_GRAV_MUL : S_SC_START;
                end
            end
            S_GRAV_MUL: n_state = S_GRAV_ACC;
            S_GRAV_ACC: n_state = (k3 == 2'd2) ? S_SQ_MUL : S_GRAV_MUL;
            S_SQ_MUL:   n_state = S_SQ_ACC;
            S_SQ_ACC:   n_state = (k3 == 2'd2) ? S_SQRT : S_SQ_MUL;
            S_SQRT: begin
                if (r_cnt == IT_W'(1)) begin
                    n_state = S_SQ_DONE;
                end
            end
            S_SQ_DONE: begin
                case (r_sel)
                    VS_ACC:  n_state = S_SQ_MUL;
                    VS_GYR:  n_state = (r_phase == PH_CAL) ? S_CAL_UPD : S_SQ_MUL;
                    VS_BASE: n_state = n_small ? S_BIAS_START : S_UN_START;
                    VS_GRAV: n_state = n_small ? S_DOT_MUL : S_UN_START;
                    default: n_state = S_FINISH;
                endcase
            end
            S_CAL_UPD:  n_state = cal_done ? S_SQ_MUL : S_FINISH;
            S_UN_START: n_state = S_UN_DIV;
            S_UN_DIV: begin
                if (div_last) begin
                    if (k3 != 2'd2) begin
                        n_state = S_UN_START;
                    end else begin
                        n_state = (r_sel == VS_BASE) ? S_BIAS_START : S_DOT_MUL;
                    end
                end
            end
            S_BIAS_START: n_state = S_BIAS_DIV;
            S_BIAS_DIV: begin
                if (div_last) begin
                    n_state = (k3 == 2'd2) ? S_FINISH : S_BIAS_START;
                end
            end
            S_DOT_MUL: n_state = S_DOT_ACC;
            S_DOT_ACC: n_state = (k3 == 2'd2) ? S_DECIDE : S_DOT_MUL;
            S_DECIDE:  n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_phase   <= PH_CAL;
            r_last    <= '0;
            r_cand_ok <= 1'b0;
            r_flat_ok <= 1'b0;
            r_lift_ok <= 1'b0;
            r_qc      <= '0;
            r_primed  <= 1'b0;
            r_sel     <= VS_ACC;
            r_k       <= '0;
            r_cnt     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_bsum[i]  <= '0;
                r_gbsum[i] <= '0;
                r_bu[i]    <= '0;
                r_gb[i]    <= '0;
                r_gf[i]    <= '0;
            end
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (rt_clr) begin
                r_phase   <= PH_CAL;
                r_last    <= '0;
                r_cand_ok <= 1'b0;
                r_flat_ok <= 1'b0;
                r_lift_ok <= 1'b0;
                r_qc      <= '0;
                r_primed  <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_bsum[i]  <= '0;
                    r_gbsum[i] <= '0;
                    r_bu[i]    <= '0;
                    r_gb[i]    <= '0;
                    r_gf[i]    <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now    <= i_now_ms;
                        r_raw[0] <= i_accel_x;
                        r_raw[1] <= i_accel_y;
                        r_raw[2] <= i_accel_z;
                        r_raw[3] <= i_gyro_x;
                        r_raw[4] <= i_gyro_y;
                        r_raw[5] <= i_gyro_z;
                        r_k      <= '0;
                        r_ev     <= EV_NONE;
                        if (!r_enable) begin
                            r_out_vld  <= 1'b1;
                            r_out_ev   <= EV_NONE;
                            r_out_cal  <= 1'b0;
                            r_out_used <= 1'b0;
                        end else if (i_mode) begin
                            r_out_vld  <= 1'b1;
                            r_out_ev   <= EV_NONE;
                            r_out_cal  <= 1'b1;
                            r_out_used <= 1'b0;
                        end else if (!gate_ok || !i_read_ok) begin
                            if (gate_ok) begin
                                r_last <= i_now_ms;
                            end
                            r_out_vld  <= 1'b1;
                            r_out_ev   <= EV_NONE;
                            r_out_cal  <= (r_phase == PH_CAL);
                            r_out_used <= 1'b0;
                        end else begin
                            r_last <= i_now_ms;
                        end
                    end
                end
                S_SC_START: begin
                    r_neg <= raw_x[RAW_BITS];
                    r_quo <= sc_dvd;
                    r_rem <= '0;
                    r_dvs <= DVS_W'(sc_div);
                    r_cnt <= IT_W'(DVD_W);
                end
                S_SC_DIV: begin
                    r_quo <= div_q;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt - IT_W'(1);
                    if (div_last) begin
                        if (sc_acc) begin
                            r_a[k3] <= sc_sv[15:0];
                        end else begin
                            r_g[2'(r_k - 3'd3)] <= sc_sv[19:0];
                        end
                        r_k <= (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
                    end
                end
                S_GRAV_ACC: begin
                    if (r_primed) begin
                        r_gf[k3] <= r_gf[k3] + r_prod[39:16];
                    end else begin
                        r_gf[k3] <= a24;
                    end
                    if (k3 == 2'd2) begin
                        r_primed <= 1'b1;
                        r_k      <= '0;
                        r_sel    <= VS_ACC;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_SQ_ACC: begin
                    if (k3 == 2'd2) begin
                        r_sn  <= r_sq + SQ_W'(r_prod);
                        r_sr  <= '0;
                        r_sb  <= SQ_W'(1) << (SQ_W - 2);
                        r_cnt <= IT_W'(MUL_W);
                        r_k   <= '0;
                    end else begin
                        r_sq <= ((k3 == 2'd0) ? '0 : r_sq) + SQ_W'(r_prod);
                        r_k  <= r_k + 3'd1;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_sn <= r_sn - sq_rb;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb  <= r_sb >> 2;
                    r_cnt <= r_cnt - IT_W'(1);
                end
                S_SQ_DONE: begin
                    r_k   <= '0;
                    r_nrm <= sq_n;
                    r_dot <= '0;
                    case (r_sel)
                        VS_ACC: begin
                            r_ad  <= (sq_n >= MUL_W'(ONE_G_Q13)) ? sq_n - MUL_W'(ONE_G_Q13)
                                                                 : MUL_W'(ONE_G_Q13) - sq_n;
                            r_sel <= VS_GYR;
                        end
                        VS_GYR: begin
                            r_gn  <= sq_n;
                            r_sel <= VS_GRAV;
                        end
                        VS_BASE: begin
                            if (n_small) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_bu[i] <= '0;
                                end
                            end
                        end
                        VS_GRAV: begin
                            if (n_small) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_gu[i] <= '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_CAL_UPD: begin
                    r_qc <= qc_new;
                    for (int i = 0; i < 3; i++) begin
                        if (cal_quiet) begin
                            r_bsum[i]  <= r_bsum[i] + BS_W'(r_gf[i] >>> 8);
                            r_gbsum[i] <= r_gbsum[i] + GB_W'(r_g[i]);
                        end else begin
                            r_bsum[i]  <= '0;
                            r_gbsum[i] <= '0;
                        end
                    end
                    r_sel <= VS_BASE;
                    r_k   <= '0;
                    r_ev  <= EV_NONE;
                end
                S_UN_START: begin
                    r_neg <= vec_el[MUL_W-1];
                    r_quo <= DVD_W'(vec_mag) << UNIT_SHIFT;
                    r_rem <= '0;
                    r_dvs <= r_nrm;
                    r_cnt <= IT_W'(DVD_W);
                end
                S_UN_DIV: begin
                    r_quo <= div_q;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt - IT_W'(1);
                    if (div_last) begin
                        if (r_sel == VS_BASE) begin
                            r_bu[k3] <= r_neg ? 16'(-un_qc) : un_qc;
                        end else begin
                            r_gu[k3] <= r_neg ? 16'(-un_qc) : un_qc;
                        end
                        r_k <= (k3 == 2'd2) ? 3'd0 : r_k + 3'd1;
                    end
                end
                S_BIAS_START: begin
                    r_neg <= r_gbsum[k3][GB_W-1];
                    r_quo <= DVD_W'(gb_mag);
                    r_rem <= '0;
                    r_dvs <= DVS_W'(r_qc);
                    r_cnt <= IT_W'(DVD_W);
                end
                S_BIAS_DIV: begin
                    r_quo <= div_q;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt - IT_W'(1);
                    if (div_last) begin
                        r_gb[k3] <= r_neg ? 20'(-div_q[19:0]) : div_q[19:0];
                        if (k3 == 2'd2) begin
                            r_k       <= '0;
                            r_phase   <= PH_FLAT;
                            r_flat_t  <= r_now;
                            r_flat_ok <= 1'b1;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                S_DOT_ACC: begin
                    r_dot <= r_dot + $signed(r_prod[35:0]);
                    r_k   <= (k3 == 2'd2) ? 3'd0 : r_k + 3'd1;
                end
                S_DECIDE: begin
                    r_phase   <= n_phase;
                    r_cand_ok <= n_cand_ok;
                    r_cand_t  <= n_cand_t;
                    r_flat_ok <= n_flat_ok;
                    r_flat_t  <= n_flat_t;
                    r_lift_ok <= n_lift_ok;
                    r_lift_t  <= n_lift_t;
                    r_ev      <= n_ev;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_ev   <= r_ev;
                        r_out_cal  <= (r_phase == PH_CAL);
                        r_out_used <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while a sample is in progress");

    a_event_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_NONE) |-> (o_sample_used && !o_calibrating))
        else $error("event reported without a used sample");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res == EV_NONE || o_event_res == EV_LIFTED
                         || o_event_res == EV_FLAT))
        else $error("undefined event code");

    a_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_DIV || r_state == S_UN_DIV || r_state == S_BIAS_DIV)
        |-> (r_dvs != '0))
        else $error("divide by zero in shared divider");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state == S_IDLE) || $past(r_state == S_FINISH)))
        else $error("result written outside idle or finish");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import imlf_pkg::*;

    localparam longint LIMIT = 8000000;

    typedef struct {
        bit          mode;
        bit [31:0]   now;
        bit          rd;
        shortint     ax, ay, az, gx, gy, gz;
    } poll_t;

    typedef struct {
        bit          mode;
        bit [31:0]   now;
        bit          rd;
        shortint     ax, ay, az, gx, gy, gz;
        bit          chk;
        bit [1:0]    ev;
        bit          cal;
        bit          used;
    } row_t;

    typedef struct {
        bit [1:0] ev;
        bit       cal;
        bit       used;
    } res_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode = 1'b0;
    logic [31:0]           i_now_ms = '0;
    logic                  i_read_ok = 1'b0;
    logic signed [15:0]    i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [15:0]    i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_event_res;
    logic                  o_calibrating;
    logic                  o_sample_used;

    imu_lift_flat_detector uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_now_ms(i_now_ms), .i_read_ok(i_read_ok),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_gyro_x(i_gyro_x), .i_gyro_y(i_gyro_y), .i_gyro_z(i_gyro_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_event_res(o_event_res), .o_calibrating(o_calibrating),
        .o_sample_used(o_sample_used)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register copies and detector state of the predictor.
    bit     en;
    longint cpg, gcpd, intv, ncal, lift_ms, flat_ms, minl_ms;
    t_phase ph;
    bit [31:0] last_t, cand_t, flat_t, lift_t;
    bit     cand_v, flat_v, lift_v, primed;
    int     quiet;
    longint base_sum[3], bias_sum[3], base_unit[3], bias[3], grav[3];

    res_t   pending[$];
    int     errs = 0;
    int     sent = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    longint cycles = 0;
    bit [31:0] t_base;
    int     pose = 0;
    int     pose_left = 0;

    function automatic void clear_run_state();
        ph = PH_CAL;
        last_t = '0;
        cand_v = 0; flat_v = 0; lift_v = 0;
        cand_t = '0; flat_t = '0; lift_t = '0;
        quiet = 0;
        primed = 0;
        for (int i = 0; i < 3; i++) begin
            base_sum[i] = 0; bias_sum[i] = 0; base_unit[i] = 0;
            bias[i] = 0; grav[i] = 0;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        case (idx)
            CFG_ENABLE: begin
                if (!en && val[0]) clear_run_state();
                en = val[0];
            end
            CFG_ACCEL_CPG:    cpg = val & 16'h7FFF;
            CFG_GYRO_CPD:     gcpd = val & 16'hFFFF;
            CFG_INTERVAL:     intv = val & 10'h3FF;
            CFG_CAL_SAMPLES:  ncal = val & 7'h7F;
            CFG_LIFT_CONFIRM: lift_ms = val & 14'h3FFF;
            CFG_FLAT_CONFIRM: flat_ms = val & 14'h3FFF;
            CFG_MIN_LIFTED:   minl_ms = val & 16'hFFFF;
            default: ;
        endcase
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint to_fixed(longint raw, longint mul, longint div, longint lim);
        longint mag;
        longint q;
        mag = raw < 0 ? -raw : raw;
        if (div == 0) div = 1;
        q = (mag * mul + div / 2) / div;
        if (raw < 0) q = -q;
        if (q > lim - 1) q = lim - 1;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic longint vec_len(longint v[3]);
        longint unsigned s = 0;
        for (int i = 0; i < 3; i++) s += v[i] * v[i];
        return longint'(int_sqrt(s));
    endfunction

    function automatic void to_unit(input longint v[3], input longint one,
                                    output longint u[3]);
        longint n;
        longint m;
        longint q;
        n = vec_len(v);
        for (int i = 0; i < 3; i++) begin
            if (n * 1000 < one) begin
                u[i] = 0;
            end else begin
                m = v[i] < 0 ? -v[i] : v[i];
                q = (m << 15) / n;
                if (q > 32767) q = 32767;
                u[i] = v[i] < 0 ? -q : q;
            end
        end
    endfunction

    function automatic res_t detect(poll_t p);
        res_t r;
        longint a[3], g[3], gu[3];
        longint ad, gn, dot, fd, need;
        bit stable, ret, lifted, pickup;
        bit [31:0] d;
        r = '{ev: EV_NONE, cal: 0, used: 0};
        if (!en) return r;
        if (p.mode) begin
            clear_run_state();
            r.cal = 1;
            return r;
        end
        d = p.now - last_t;
        if (d < intv) begin
            r.cal = ph == PH_CAL;
            return r;
        end
        last_t = p.now;
        if (!p.rd) begin
            r.cal = ph == PH_CAL;
            return r;
        end
        r.used = 1;
        a[0] = to_fixed(p.ax, 8192, cpg, 32768);
        a[1] = to_fixed(p.ay, 8192, cpg, 32768);
        a[2] = to_fixed(p.az, 8192, cpg, 32768);
        g[0] = to_fixed(p.gx, 4096, gcpd, 524288);
        g[1] = to_fixed(p.gy, 4096, gcpd, 524288);
        g[2] = to_fixed(p.gz, 4096, gcpd, 524288);
        for (int i = 0; i < 3; i++) begin
            if (!primed) grav[i] = a[i] * 256;
            else grav[i] += ((a[i] * 256 - grav[i]) * GRAV_ALPHA) >>> 16;
        end
        primed = 1;
        ad = vec_len(a) - ONE_G_Q13;
        if (ad < 0) ad = -ad;

        if (ph == PH_CAL) begin
            need = ncal != 0 ? ncal : 1;
            if (ad < ACC_CAL && vec_len(g) < GYR_CAL) begin
                for (int i = 0; i < 3; i++) begin
                    base_sum[i] += grav[i] >>> 8;
                    bias_sum[i] += g[i];
                end
                if (quiet < 127) quiet++;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    base_sum[i] = 0;
                    bias_sum[i] = 0;
                end
                quiet = 0;
            end
            if (quiet >= need) begin
                to_unit(base_sum, 8192, base_unit);
                for (int i = 0; i < 3; i++) bias[i] = bias_sum[i] / quiet;
                ph = PH_FLAT;
                flat_t = p.now;
                flat_v = 1;
            end
            r.cal = ph == PH_CAL;
            return r;
        end

        for (int i = 0; i < 3; i++) g[i] -= bias[i];
        to_unit(grav, 2097152, gu);
        dot = 0;
        for (int i = 0; i < 3; i++) dot += gu[i] * base_unit[i];
        if (dot < 0) dot = -dot;
        fd = dot >> 15;
        gn = vec_len(g);
        stable = fd > DOT_FLAT && gn < GYR_STATIC && ad < ACC_STATIC;
        ret = fd > DOT_RETURN && gn < GYR_RETURN && ad < ACC_RETURN;
        lifted = fd < DOT_LIFT;
        pickup = gn > GYR_PICKUP || ad > ACC_PICKUP;

        if (ph == PH_FLAT) begin
            if (pickup) cand_v = 0;
            if (lifted) begin
                if (!cand_v) begin
                    cand_t = p.now;
                    cand_v = 1;
                end
                d = p.now - cand_t;
                if (d >= lift_ms) begin
                    ph = PH_LIFT;
                    lift_t = p.now;
                    lift_v = 1;
                    cand_v = 0;
                    flat_v = 0;
                    r.ev = EV_LIFTED;
                end
            end else begin
                cand_v = 0;
            end
        end else if (stable || ret) begin
            if (!flat_v) begin
                flat_t = p.now;
                flat_v = 1;
            end
            if ((!lift_v || 32'(p.now - lift_t) >= minl_ms) &&
                32'(p.now - flat_t) >= flat_ms) begin
                ph = PH_FLAT;
                flat_t = p.now;
                r.ev = EV_FLAT;
            end
        end else begin
            flat_v = 0;
        end
        return r;
    endfunction

    function automatic shortint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return shortint'(v);
    endfunction

    function automatic longint jitter(longint n);
        return longint'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic poll_t next_poll();
        poll_t p;
        int r;
        longint bx, by, bz, an, gnz, gmul;
        r = $urandom_range(0, 99);
        p.mode = 0;
        p.rd = 1;
        if (r < 79) begin
            if (pose_left == 0) begin
                pose = $urandom_range(0, 5);
                pose_left = $urandom_range(5, 60);
            end
            pose_left--;
            p.now = t_base + 32'(intv) + $urandom_range(0, 3);
            t_base = p.now;
            p.rd = $urandom_range(0, 49) != 0;
            gmul = 1;
            case (pose)
                0: begin bx = 0; by = 0; bz = cpg; end
                1: begin bx = 0; by = 0; bz = -cpg; end
                2: begin bx = cpg; by = 0; bz = 0; end
                3: begin bx = 0; by = cpg * 7 / 10; bz = cpg * 7 / 10; end
                4: begin bx = cpg / 8; by = 0; bz = cpg; end
                default: begin bx = 0; by = cpg / 2; bz = 2 * cpg; gmul = 40; end
            endcase
            an = cpg >> 6;
            gnz = ((gcpd >> 8) + 1) * gmul;
            p.ax = clip16(bx + jitter(an));
            p.ay = clip16(by + jitter(an));
            p.az = clip16(bz + jitter(an));
            p.gx = clip16(jitter(gnz));
            p.gy = clip16(jitter(gnz));
            p.gz = clip16(jitter(gnz));
        end else begin
            p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
            p.gx = $urandom; p.gy = $urandom; p.gz = $urandom;
            if (r < 80) begin
                p.mode = 1;
                p.now = $urandom;
            end else if (r < 89) begin
                p.now = t_base + $urandom_range(0, 32'(intv));
            end else begin
                p.mode = $urandom_range(0, 1);
                p.rd = $urandom_range(0, 1);
                p.now = $urandom;
            end
        end
        return p;
    endfunction

    task automatic send(poll_t p, bit chk, res_t typed);
        res_t r;
        if (sent < 500) begin
            idle_pct = 14; stall_pct = 85;
        end else if (sent < 1000) begin
            idle_pct = 85; stall_pct = 14;
        end else begin
            idle_pct = 0; stall_pct = 0;
        end
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= p.mode;
        i_now_ms <= p.now;
        i_read_ok <= p.rd;
        i_accel_x <= p.ax; i_accel_y <= p.ay; i_accel_z <= p.az;
        i_gyro_x <= p.gx; i_gyro_y <= p.gy; i_gyro_z <= p.gz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = detect(p);
        pending.push_back(chk ? typed : r);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val[15:0];
        apply_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_regs(longint a, longint g, longint iv, longint nc,
                            longint lc, longint fc, longint ml);
        write_reg(CFG_ACCEL_CPG, a);
        write_reg(CFG_GYRO_CPD, g);
        write_reg(CFG_INTERVAL, iv);
        write_reg(CFG_CAL_SAMPLES, nc);
        write_reg(CFG_LIFT_CONFIRM, lc);
        write_reg(CFG_FLAT_CONFIRM, fc);
        write_reg(CFG_MIN_LIFTED, ml);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send(next_poll(), 0, '{EV_NONE, 0, 0});
        drain();
    endtask

    row_t dir_rows[26] = '{
        '{1, 32'd5, 1, 16'sd32767, 0, 0, 0, 0, 0, 1, EV_NONE, 0, 0},
        '{0, 32'd900, 1, -16'sd32768, 0, 0, 0, 0, 16'sd32767, 1, EV_NONE, 0, 0},
        '{1, 32'd100, 1, 0, 0, 8192, 0, 0, 0, 1, EV_NONE, 1, 0},
        '{0, 32'd100, 0, 0, 0, 8192, 0, 0, 0, 1, EV_NONE, 1, 0},
        '{0, 32'd110, 1, 0, 0, 8192, 0, 0, 0, 1, EV_NONE, 1, 0},
        '{0, 32'd200, 1, 32767, 32767, 32767, -32768, -32768, -32768,
          1, EV_NONE, 1, 1},
        '{0, 32'd220, 1, -32768, -32768, -32768, 32767, 32767, 32767,
          1, EV_NONE, 1, 1},
        '{0, 32'hFFFF_FFF0, 1, 0, 0, 8192, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'h0000_0004, 1, 0, 0, 8192, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{1, 32'd10, 1, 0, 0, 8192, 0, 0, 0, 1, EV_NONE, 1, 0},
        '{0, 32'd40, 1, 20, -10, 8192, 5, -5, 3, 0, EV_NONE, 0, 0},
        '{0, 32'd60, 1, -15, 10, 8190, -4, 6, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd80, 1, 5, 0, 8200, 2, 0, -2, 0, EV_NONE, 0, 0},
        '{0, 32'd100, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd120, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd140, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd160, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd180, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd200, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd220, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd240, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd260, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd280, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd300, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd320, 1, 8192, 0, 0, 0, 0, 0, 0, EV_NONE, 0, 0},
        '{0, 32'd340, 1, 16384, 0, 0, 30000, 0, 0, 0, EV_NONE, 0, 0}
    };

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        res_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errs++;
            end else begin
                e = pending.pop_front();
                if (o_event_res !== e.ev) begin
                    $error("event_res: expected %0d, got %0d", e.ev, o_event_res);
                    errs++;
                end
                if (o_calibrating !== e.cal) begin
                    $error("calibrating: expected %0d, got %0d", e.cal, o_calibrating);
                    errs++;
                end
                if (o_sample_used !== e.used) begin
                    $error("sample_used: expected %0d, got %0d", e.used, o_sample_used);
                    errs++;
                end
            end
        end
    end

    initial begin
        poll_t p;
        res_t  typed;
        en = 0;
        cpg = RST_ACCEL_CPG; gcpd = RST_GYRO_CPD; intv = RST_INTERVAL;
        ncal = RST_CAL_SAMPLES; lift_ms = RST_LIFT_CONFIRM;
        flat_ms = RST_FLAT_CONFIRM; minl_ms = RST_MIN_LIFTED;
        clear_run_state();
        t_base = $urandom;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < 26; k++) begin
            if (k == 2) begin
                drain();
                set_regs(8192, 16768, 20, 3, 40, 650, 800);
                write_reg(CFG_ENABLE, 1);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
            end
            p = '{dir_rows[k].mode, dir_rows[k].now, dir_rows[k].rd,
                  dir_rows[k].ax, dir_rows[k].ay, dir_rows[k].az,
                  dir_rows[k].gx, dir_rows[k].gy, dir_rows[k].gz};
            typed = '{dir_rows[k].ev, dir_rows[k].cal, dir_rows[k].used};
            send(p, dir_rows[k].chk, typed);
        end
        drain();

        t_base = $urandom;
        set_regs(8192, 16768, 20, 5, 80, 650, 800);
        run_random(420);

        set_regs(32767, 65535, 0, 1, 0, 0, 0);
        run_random(300);

        set_regs(1024, 256, 1000, 127, 10000, 10000, 60000);
        run_random(320);

        set_regs(0, 0, 0, 0, 0, 0, 0);
        run_random(80);

        write_reg(CFG_ENABLE, 0);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        run_random(30);
        set_regs(4096, 8000, 10, 8, 60, 200, 300);
        write_reg(CFG_ENABLE, 1);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        run_random(380);

        repeat (1000) @(negedge i_clk);
        if (errs == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
